/* rtl/core/rvm_pkg.sv */
package rvm_pkg;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;
    localparam int WORD_W    = 32;
    localparam int LONG_W    = 64;
    localparam int IDX_FIELD = 8;

    typedef enum logic [2:0] {
        OP_ADD32   = 3'd0,
        OP_ADD64   = 3'd1,
        OP_RET     = 3'd2,
        OP_LOAD32  = 3'd3,
        OP_STORE32 = 3'd4,
        OP_CONST32 = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_BADOP   = 2'd1,
        ST_BADADDR = 2'd2
    } status_t;

    // status sits in the low bits so the struct packs straight onto m_tdata
    typedef struct packed {
        logic [LONG_W-1:0] value;
        status_t           status;
    } result_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

/* rtl/core/rvm_data_mem.sv */
module rvm_data_mem #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                         aclk,
    input  rvm_pkg::mem_cmd_t            cmd,
    input  logic [$clog2(MEM_BYTES)-1:0] addr,
    input  logic [31:0]                  wdata,
    output logic [31:0]                  rdata
);
    import rvm_pkg::*;

    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int ROW_W     = ADDR_W - 2;
    localparam int ROW_COUNT = (MEM_BYTES + 3) / 4;

    logic [ROW_W-1:0] row_base;
    logic [1:0]       sel;
    logic [1:0]       sel_reg;
    logic [7:0]       lane_q_reg [4];

    assign row_base = addr[ADDR_W-1:2];
    assign sel      = addr[1:0];

    // Four byte lanes; lane k holds bytes whose address is k modulo 4,
    // so an unaligned word touches each lane exactly once.
    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic [7:0]       lane_mem [ROW_COUNT];
        logic [ROW_W-1:0] row;
        logic [1:0]       byte_sel;

        // lanes below the start lane wrap into the next row
        assign row      = row_base + ROW_W'((2'(k) < sel) ? 1 : 0);
        assign byte_sel = 2'(k) - sel;

        always_ff @(posedge aclk) begin
            if (cmd.wr) begin
                lane_mem[row] <= wdata[byte_sel*8 +: 8];
            end
            if (cmd.rd) begin
                lane_q_reg[k] <= lane_mem[row];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            sel_reg <= sel;
        end
    end

    // reassemble little-endian from the lane that held each byte
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            rdata[j*8 +: 8] = lane_q_reg[2'(sel_reg + 2'(j))];
        end
    end

endmodule

/* rtl/core/register_vm_instruction_executor.sv */
// Register VM instruction executor.
// s_ channel: one instruction per transfer (add32, add64, return, load32,
//   store32, const32). m_ channel: one result per instruction, status plus
//   the value written to a register or to memory (zero on error).
// cfg_ channel: writes the return register index; write it only while idle.
// Register operations pass through register read, then execute and write
//   back; load32 adds a data memory read after execute. An instruction is
//   taken only while execute is empty: the banks are read as it is taken,
//   it executes from those reads, and the following instruction reads again
//   while a load completes, through a one-entry write bypass.
// Results collect in a two-entry output queue; s_tready drops when the queue
//   together with a load in flight could not take another result, so a
//   stalled receiver backs up onto the input and nothing is lost.
// Reset: aresetn low clears control state and starts a clearing pass that
//   zeroes both register banks and the data memory, one row a cycle.
//   s_tready stays low during the pass; cfg writes are accepted throughout.
module register_vm_instruction_executor #(
    parameter int REG_COUNT = 256,
    parameter int MEM_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    // fields from bit 0: opcode[3], dest_reg[8], src_reg_a[8], src_reg_b[8],
    // offset[32], zero pad[5]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // fields from bit 0: status[2], written_value[64], zero pad[6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    // return_register[8]
    input  logic        cfg_tvalid,
    output logic        cfg_tready,
    input  logic [7:0]  cfg_tdata
);
    import rvm_pkg::*;

    localparam int IDX_W     = $clog2(REG_COUNT);
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int ROW_W     = ADDR_W - 2;
    localparam int ROW_COUNT = (MEM_BYTES + 3) / 4;
    localparam int CLEAR_LEN = (REG_COUNT > ROW_COUNT) ? REG_COUNT : ROW_COUNT;
    localparam int CLR_W     = $clog2(CLEAR_LEN);
    localparam logic [33:0] ADDR_LIMIT = 34'(MEM_BYTES - 4);

    // register index reduction, folded into a constant table
    typedef logic [IDX_W-1:0] idx_table_t [256];

    function automatic idx_table_t build_idx_table();
        idx_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = IDX_W'(i % REG_COUNT);
        end
        return t;
    endfunction

    localparam idx_table_t IDX_TABLE = build_idx_table();

    // input fields
    logic [2:0]       in_op;
    logic [7:0]       in_dest;
    logic [7:0]       in_src_a;
    logic [7:0]       in_src_b;
    logic [31:0]      in_offset;
    logic [IDX_W-1:0] in_d_idx;
    logic [IDX_W-1:0] in_a_idx;
    logic [IDX_W-1:0] in_b_idx;
    logic [IDX_W-1:0] rd1_idx;
    logic [IDX_W-1:0] rd2_idx;
    logic             accept;

    assign in_op     = s_tdata[2:0];
    assign in_dest   = s_tdata[10:3];
    assign in_src_a  = s_tdata[18:11];
    assign in_src_b  = s_tdata[26:19];
    assign in_offset = s_tdata[58:27];
    assign in_d_idx  = IDX_TABLE[in_dest];
    assign in_a_idx  = IDX_TABLE[in_src_a];
    assign in_b_idx  = IDX_TABLE[in_src_b];
    assign accept    = s_tvalid && s_tready;

    // word port 1 carries the base or first addend; return reads dest here.
    // word port 2 carries the second addend; store reads its data here.
    assign rd1_idx = (opcode_t'(in_op) == OP_RET) ? in_d_idx : in_a_idx;
    assign rd2_idx = (opcode_t'(in_op) == OP_STORE32) ? in_d_idx : in_b_idx;

    // control state
    logic             clearing_reg;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic [7:0]       ret_reg;
    logic             ex_valid_reg;
    logic             ld_valid_reg;
    logic [1:0]       count_reg;

    // execute stage payload
    logic [2:0]       ex_op_reg;
    logic [IDX_W-1:0] ex_d_reg;
    logic [IDX_W-1:0] ex_a_reg;
    logic [IDX_W-1:0] ex_b_reg;
    logic [IDX_W-1:0] ex_p1_reg;
    logic [IDX_W-1:0] ex_p2_reg;
    logic [31:0]      ex_offset_reg;
    logic [IDX_W-1:0] ld_d_reg;

    // register banks and their read data
    logic [31:0] word_mem [REG_COUNT];
    logic [63:0] long_mem [REG_COUNT];
    logic [31:0] wq1_reg;
    logic [31:0] wq2_reg;
    logic [63:0] lq1_reg;
    logic [63:0] lq2_reg;

    // last write, for reads issued in the same cycle
    logic             bw_valid_reg;
    logic [IDX_W-1:0] bw_idx_reg;
    logic [31:0]      bw_data_reg;
    logic             bl_valid_reg;
    logic [IDX_W-1:0] bl_idx_reg;
    logic [63:0]      bl_data_reg;

    // output queue
    result_t q0_reg;
    result_t q1_reg;

    // write ports
    logic             w_wen;
    logic [IDX_W-1:0] w_idx;
    logic [31:0]      w_data;
    logic             l_wen;
    logic [IDX_W-1:0] l_idx;
    logic [63:0]      l_data;

    // execute logic
    logic [31:0]      wa;
    logic [31:0]      wb;
    logic [63:0]      la;
    logic [63:0]      lb;
    logic [33:0]      addr_sum;
    logic             addr_ok;
    logic             push;
    result_t          push_data;
    logic             ld_start;
    mem_cmd_t         mem_cmd;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]      mem_wdata;
    logic [31:0]      mem_rdata;
    logic             pop;
    logic             clr_regs;
    logic             clr_rows;

    assign clr_regs = clearing_reg &&
                      ({1'b0, clr_cnt_reg} < (CLR_W+1)'(REG_COUNT));
    assign clr_rows = clearing_reg &&
                      ({1'b0, clr_cnt_reg} < (CLR_W+1)'(ROW_COUNT));

    // take a new instruction only when execute is free and the queue has room
    // for every result already in flight plus this one
    assign s_tready   = !clearing_reg && !ex_valid_reg &&
                        ((2'(ld_valid_reg) + count_reg) < 2'd2);
    assign cfg_tready = 1'b1;

    // operands with bypass of a write made while they were read
    assign wa = (bw_valid_reg && bw_idx_reg == ex_p1_reg) ? bw_data_reg : wq1_reg;
    assign wb = (bw_valid_reg && bw_idx_reg == ex_p2_reg) ? bw_data_reg : wq2_reg;
    assign la = (bl_valid_reg && bl_idx_reg == ex_a_reg) ? bl_data_reg : lq1_reg;
    assign lb = (bl_valid_reg && bl_idx_reg == ex_b_reg) ? bl_data_reg : lq2_reg;

    // exact base plus signed offset, no wrap
    assign addr_sum = {2'b00, wa} + {{2{ex_offset_reg[31]}}, ex_offset_reg};
    assign addr_ok  = !addr_sum[33] && (addr_sum <= ADDR_LIMIT);

    always_comb begin
        w_wen     = 1'b0;
        w_idx     = ex_d_reg;
        w_data    = '0;
        l_wen     = 1'b0;
        l_idx     = ex_d_reg;
        l_data    = '0;
        push      = 1'b0;
        push_data = '{value: '0, status: ST_DONE};
        ld_start  = 1'b0;
        mem_cmd   = '{rd: 1'b0, wr: 1'b0};
        mem_addr  = addr_sum[ADDR_W-1:0];
        mem_wdata = wb;

        if (clearing_reg) begin
            w_wen     = clr_regs;
            w_idx     = clr_cnt_reg[IDX_W-1:0];
            l_wen     = clr_regs;
            l_idx     = clr_cnt_reg[IDX_W-1:0];
            mem_cmd   = '{rd: 1'b0, wr: clr_rows};
            mem_addr  = {clr_cnt_reg[ROW_W-1:0], 2'b00};
            mem_wdata = '0;
        end else if (ld_valid_reg) begin
            // load completes: data memory word goes to the register bank
            w_wen     = 1'b1;
            w_idx     = ld_d_reg;
            w_data    = mem_rdata;
            push      = 1'b1;
            push_data = '{value: {32'd0, mem_rdata}, status: ST_DONE};
        end else if (ex_valid_reg) begin
            push = 1'b1;
            unique case (opcode_t'(ex_op_reg))
                OP_ADD32: begin
                    w_wen     = 1'b1;
                    w_data    = wa + wb;
                    push_data = '{value: {32'd0, wa + wb}, status: ST_DONE};
                end
                OP_ADD64: begin
                    l_wen     = 1'b1;
                    l_data    = la + lb;
                    push_data = '{value: la + lb, status: ST_DONE};
                end
                OP_RET: begin
                    w_wen     = 1'b1;
                    w_idx     = IDX_TABLE[ret_reg];
                    w_data    = wa;
                    push_data = '{value: {32'd0, wa}, status: ST_DONE};
                end
                OP_CONST32: begin
                    w_wen     = 1'b1;
                    w_data    = ex_offset_reg;
                    push_data = '{value: {32'd0, ex_offset_reg}, status: ST_DONE};
                end
                OP_LOAD32: begin
                    if (addr_ok) begin
                        push     = 1'b0;
                        ld_start = 1'b1;
                        mem_cmd  = '{rd: 1'b1, wr: 1'b0};
                    end else begin
                        push_data = '{value: '0, status: ST_BADADDR};
                    end
                end
                OP_STORE32: begin
                    if (addr_ok) begin
                        mem_cmd   = '{rd: 1'b0, wr: 1'b1};
                        push_data = '{value: {32'd0, wb}, status: ST_DONE};
                    end else begin
                        push_data = '{value: '0, status: ST_BADADDR};
                    end
                end
                default: begin
                    push_data = '{value: '0, status: ST_BADOP};
                end
            endcase
        end
    end

    rvm_data_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_data_mem (
        .aclk  (aclk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // register banks: one write port, two read ports each, registered reads
    always_ff @(posedge aclk) begin
        if (w_wen) begin
            word_mem[w_idx] <= w_data;
        end
        if (l_wen) begin
            long_mem[l_idx] <= l_data;
        end
        if (accept) begin
            wq1_reg <= word_mem[rd1_idx];
            wq2_reg <= word_mem[rd2_idx];
            lq1_reg <= long_mem[in_a_idx];
            lq2_reg <= long_mem[in_b_idx];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        bw_idx_reg  <= w_idx;
        bw_data_reg <= w_data;
        bl_idx_reg  <= l_idx;
        bl_data_reg <= l_data;
        if (accept) begin
            ex_op_reg     <= in_op;
            ex_d_reg      <= in_d_idx;
            ex_a_reg      <= in_a_idx;
            ex_b_reg      <= in_b_idx;
            ex_p1_reg     <= rd1_idx;
            ex_p2_reg     <= rd2_idx;
            ex_offset_reg <= in_offset;
        end
        if (ld_start) begin
            ld_d_reg <= ex_d_reg;
        end
    end

    // output queue: q0 is the head shown on m_tdata
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {6'd0, q0_reg};

    always_ff @(posedge aclk) begin
        if (pop && push) begin
            if (count_reg == 2'd1) begin
                q0_reg <= push_data;
            end else begin
                q0_reg <= q1_reg;
                q1_reg <= push_data;
            end
        end else if (pop) begin
            q0_reg <= q1_reg;
        end else if (push) begin
            if (count_reg == 2'd0) begin
                q0_reg <= push_data;
            end else begin
                q1_reg <= push_data;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            ret_reg      <= '0;
            ex_valid_reg <= 1'b0;
            ld_valid_reg <= 1'b0;
            count_reg    <= '0;
            bw_valid_reg <= 1'b0;
            bl_valid_reg <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLEAR_LEN - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_tvalid && cfg_tready) begin
                ret_reg <= cfg_tdata;
            end
            ex_valid_reg <= accept;
            ld_valid_reg <= ld_start;
            bw_valid_reg <= w_wen;
            bl_valid_reg <= l_wen;
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* tb/sv/tb_register_vm_instruction_executor.sv */
`timescale 1ns / 1ps

module tb_register_vm_instruction_executor;
    import rvm_pkg::*;

    localparam int REG_COUNT = 256;
    localparam int MEM_BYTES = 65536;

    // Opcodes the block must reject
    localparam logic [2:0] OP_INVALID6 = 3'd6;
    localparam logic [2:0] OP_INVALID7 = 3'd7;

    // The clearing pass after reset allows no input transfer; the limit leaves
    // ample room for the whole pass before calling the run hung.
    localparam int WATCHDOG_LIMIT = 70000;
    localparam int DRAIN_CYCLES   = 10;

    // Instruction as it sits on s_tdata: opcode in the low bits, offset on top
    typedef struct packed {
        logic [31:0] ofs;
        logic [7:0]  src_b;
        logic [7:0]  src_a;
        logic [7:0]  dest;
        logic [2:0]  opcode;
    } instr_t;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata    = '0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_tvalid = 1'b0;
    logic        cfg_tready;
    logic [7:0]  cfg_tdata  = '0;

    // Machine state as the block should hold it
    bit [31:0] word_bank [REG_COUNT];
    bit [63:0] long_bank [REG_COUNT];
    bit [7:0]  mem_image [MEM_BYTES];
    bit [7:0]  ret_reg_index = '0;

    instr_t  pending_instrs[$];
    result_t predicted_results[$];
    instr_t  in_flight;

    int      errors       = 0;
    int      quiet_cycles = 0;
    int      s_gap_left   = 0;
    int      m_stall_left = 0;
    bit      idle_on      = 1'b0;
    int      hot_addr [4];

    register_vm_instruction_executor uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_tvalid (cfg_tvalid),
        .cfg_tready (cfg_tready),
        .cfg_tdata  (cfg_tdata)
    );

    always #10 aclk = ~aclk;

    // Execute one instruction against the local machine state and return the
    // result the block owes for it. Errors leave every register and byte alone.
    function automatic result_t execute_instr(instr_t ins);
        result_t     res;
        logic [31:0] word;
        logic [63:0] sum64;
        longint      ea;
        int unsigned a;
        res.status = ST_DONE;
        res.value  = '0;
        case (ins.opcode)
            OP_ADD32: begin
                word = word_bank[ins.src_a] + word_bank[ins.src_b];
                word_bank[ins.dest] = word;
                res.value = {32'd0, word};
            end
            OP_ADD64: begin
                sum64 = long_bank[ins.src_a] + long_bank[ins.src_b];
                long_bank[ins.dest] = sum64;
                res.value = sum64;
            end
            OP_RET: begin
                word = word_bank[ins.dest];
                word_bank[ret_reg_index] = word;
                res.value = {32'd0, word};
            end
            OP_LOAD32, OP_STORE32: begin
                // exact sum of unsigned base and signed offset, no wrap
                ea = longint'(word_bank[ins.src_a]) + longint'($signed(ins.ofs));
                if (ea < 0 || ea > MEM_BYTES - 4) begin
                    res.status = ST_BADADDR;
                end else begin
                    a = int'(ea);
                    if (ins.opcode == OP_LOAD32) begin
                        word = {mem_image[a + 3], mem_image[a + 2],
                                mem_image[a + 1], mem_image[a]};
                        word_bank[ins.dest] = word;
                    end else begin
                        word = word_bank[ins.dest];
                        {mem_image[a + 3], mem_image[a + 2],
                         mem_image[a + 1], mem_image[a]} = word;
                    end
                    res.value = {32'd0, word};
                end
            end
            OP_CONST32: begin
                word_bank[ins.dest] = ins.ofs;
                res.value = {32'd0, ins.ofs};
            end
            default: begin
                res.status = ST_BADOP;
            end
        endcase
        return res;
    endfunction

    // Idle stretch: mostly short, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Favor a small set of registers so instructions feed each other
    function automatic logic [7:0] pick_reg();
        if ($urandom_range(99) < 70)
            return 8'($urandom_range(31));
        return 8'($urandom_range(255));
    endfunction

    task automatic issue(input logic [2:0] op, input logic [7:0] d, input logic [7:0] a,
                         input logic [7:0] b, input logic [31:0] ofs);
        instr_t ins;
        ins.opcode = op;
        ins.dest   = d;
        ins.src_a  = a;
        ins.src_b  = b;
        ins.ofs    = ofs;
        pending_instrs.push_back(ins);
    endtask

    // Hold until the sender has nothing left and every result has come back;
    // look between edges so the driver's updates have settled.
    task automatic wait_drained();
        while (pending_instrs.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(negedge aclk);
    endtask

    // Write the return register index through its own channel; the predictor
    // takes the new value at the transfer edge.
    task automatic write_return_reg(input logic [7:0] idx);
        @(posedge aclk);
        cfg_tdata  <= idx;
        cfg_tvalid <= 1'b1;
        do @(posedge aclk); while (cfg_tready !== 1'b1);
        ret_reg_index = idx;
        cfg_tvalid <= 1'b0;
    endtask

    // Random traffic. Memory work comes as well-formed sequences: set a base
    // register to a known address, then load and store around it so loads
    // often return data that an earlier store left behind.
    task automatic gen_random(input int n);
        int          count;
        int          sel;
        int          addr;
        int          target;
        logic [7:0]  base;
        logic [7:0]  d;
        logic [31:0] ofs;
        count = 0;
        while (count < n) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                base = 8'($urandom_range(15));
                case ($urandom_range(3))
                    0:       addr = $urandom_range(64);
                    1:       addr = $urandom_range(MEM_BYTES - 4, MEM_BYTES - 68);
                    default: addr = hot_addr[$urandom_range(3)] + $urandom_range(32);
                endcase
                issue(OP_CONST32, base, 8'($urandom), 8'($urandom), 32'(addr));
                count++;
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(9))
                        7: ofs = 32'(-addr);
                        8: ofs = 32'(MEM_BYTES - 4 - addr + $urandom_range(3));
                        9: ofs = $urandom;
                        default: begin
                            target = addr + $urandom_range(16) - 8;
                            ofs    = 32'(target - addr);
                        end
                    endcase
                    if ($urandom_range(1)) begin
                        issue(OP_STORE32, pick_reg(), base, 8'($urandom), ofs);
                    end else begin
                        // keep the base intact for the rest of the sequence
                        do d = pick_reg(); while (d == base);
                        issue(OP_LOAD32, d, base, 8'($urandom), ofs);
                    end
                    count++;
                end
            end else if (sel < 50) begin
                issue(OP_CONST32, pick_reg(), 8'($urandom), 8'($urandom), $urandom);
                count++;
            end else if (sel < 65) begin
                issue(OP_ADD32, pick_reg(), pick_reg(), pick_reg(), $urandom);
                count++;
            end else if (sel < 73) begin
                issue(OP_ADD64, pick_reg(), pick_reg(), pick_reg(), $urandom);
                count++;
            end else if (sel < 83) begin
                issue(OP_RET, pick_reg(), 8'($urandom), 8'($urandom), $urandom);
                count++;
            end else if (sel < 88) begin
                issue($urandom_range(1) ? OP_INVALID6 : OP_INVALID7,
                      8'($urandom), 8'($urandom), 8'($urandom), $urandom);
                count++;
            end else begin
                // noise: memory access with raw fields, almost always out of range
                issue($urandom_range(1) ? OP_LOAD32 : OP_STORE32,
                      8'($urandom), 8'($urandom), 8'($urandom), $urandom);
                count++;
            end
        end
    endtask

    // Driver: present one instruction at a time, predict at the transfer edge,
    // then, in idle phases, now and then insert a random gap before the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_results.push_back(execute_instr(in_flight));
                if (idle_on && $urandom_range(99) < 35)
                    s_gap_left = idle_length();
            end
            // exactly one assignment to s_tvalid in this branch
            if (!s_tvalid || s_tready) begin
                if (s_gap_left > 0) begin
                    s_gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_instrs.size() != 0) begin
                    in_flight = pending_instrs.pop_front();
                    s_tdata  <= {5'd0, in_flight};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction and,
    // in idle phases, drop m_tready for random stretches.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[65:0];
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result: status %0d value %h",
                             $time, got.status, got.value);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.value !== want.value) begin
                        $display("%0t: written_value mismatch: expected %h, actual %h",
                                 $time, want.value, got.value);
                        errors++;
                    end
                end
            end
            if (m_stall_left > 0) begin
                m_stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(99) < 15)
                    m_stall_left = idle_length();
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_tvalid && cfg_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no transfer for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (hot_addr[i])
            hot_addr[i] = $urandom_range(100, MEM_BYTES - 200);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, return register at index 0
        write_return_reg(8'd0);
        idle_on = 1'b0;
        issue(OP_CONST32,  8'd1,   8'hFF, 8'hFF, 32'hFFFF_FFFF);   // all-ones constant
        issue(OP_CONST32,  8'd2,   8'd0,  8'd0,  32'h8000_0000);   // sign bit only
        issue(OP_ADD32,    8'd3,   8'd1,  8'd2,  32'hFFFF_FFFF);   // add32 wraps
        issue(OP_ADD32,    8'hFF,  8'd1,  8'd1,  32'd0);           // top register
        issue(OP_ADD64,    8'd4,   8'hFF, 8'd0,  32'd0);
        issue(OP_RET,      8'd3,   8'd0,  8'd0,  32'd0);
        issue(OP_CONST32,  8'd5,   8'd0,  8'd0,  32'd0);           // base 0
        issue(OP_STORE32,  8'd1,   8'd5,  8'd0,  32'd0);           // lowest address
        issue(OP_STORE32,  8'hFF,  8'd5,  8'd0,  32'(MEM_BYTES - 4)); // highest address
        issue(OP_LOAD32,   8'd6,   8'd5,  8'd0,  32'(MEM_BYTES - 4));
        issue(OP_LOAD32,   8'd7,   8'd5,  8'd0,  32'd2);           // unaligned
        issue(OP_LOAD32,   8'd8,   8'd5,  8'd0,  32'(MEM_BYTES - 3)); // one past the end
        issue(OP_STORE32,  8'd1,   8'd5,  8'd0,  32'hFFFF_FFFF);   // one below zero
        issue(OP_CONST32,  8'd9,   8'd0,  8'd0,  32'(MEM_BYTES - 4));
        issue(OP_LOAD32,   8'd10,  8'd9,  8'd0,  32'(-(MEM_BYTES - 4))); // negative offset
        issue(OP_LOAD32,   8'd10,  8'd9,  8'd0,  32'h7FFF_FFFF);   // largest offset
        issue(OP_STORE32,  8'd1,   8'd9,  8'd0,  32'h8000_0000);   // smallest offset
        issue(OP_LOAD32,   8'd12,  8'd1,  8'd0,  32'd1);           // would wrap to 0
        issue(OP_LOAD32,   8'd12,  8'd1,  8'd0,  32'h8000_0000);
        issue(OP_STORE32,  8'd3,   8'd2,  8'd0,  32'h8000_0000);   // huge base, offset lands on 0
        issue(OP_LOAD32,   8'd13,  8'd5,  8'd0,  32'd0);
        issue(OP_INVALID6, 8'd13,  8'd1,  8'd2,  32'hFFFF_FFFF);
        issue(OP_INVALID7, 8'd13,  8'hFF, 8'hFF, 32'hFFFF_FFFF);
        issue(OP_RET,      8'd13,  8'd0,  8'd0,  32'd0);           // invalid ops must leave r13 untouched
        wait_drained();

        // Random phases; each settles fully before the index changes
        write_return_reg(8'hFF);
        idle_on = 1'b1;
        gen_random(150);
        wait_drained();

        write_return_reg(8'($urandom_range(1, 254)));
        idle_on = 1'b0;
        gen_random(130);
        wait_drained();

        write_return_reg(8'd0);
        idle_on = 1'b1;
        gen_random(150);
        wait_drained();

        // let any stray result show up before deciding
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
